FILE: sv/lpr_pkg.sv
// Types, widths and shared helpers of the line pixel rasterizer.
// No dependencies; imported by lpr_step, line_pixel_rasterizer and tb_top.
`default_nettype none

package lpr_pkg;

	localparam int COORD_BITS = 7;
	localparam int ERR_BITS   = COORD_BITS + 2;
	localparam int CNT_BITS   = COORD_BITS + 1;

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [ERR_BITS-1:0] err_t;
	typedef logic [CNT_BITS-1:0]        cnt_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} line_req_t;

	typedef struct packed {
		coord_t pixel_a_x;
		coord_t pixel_a_y;
		coord_t pixel_b_x;
		coord_t pixel_b_y;
		logic   pixel_b_valid;
		logic   last_pair;
	} pixel_pair_t;

	typedef struct packed {
		coord_t major_span;
		coord_t minor_span;
		logic   up;
		logic   steep;
	} line_par_t;

	typedef struct packed {
		coord_t major;
		coord_t minor;
		err_t   err;
	} walk_t;

	function automatic err_t to_err(input coord_t v);
		return $signed({{(ERR_BITS-COORD_BITS){1'b0}}, v});
	endfunction

endpackage

`default_nettype wire

FILE: sv/line_pixel_rasterizer.sv
// Line pixel rasterizer top level: setup sequencer, walk state and output register.
// Depends on lpr_pkg and lpr_step.
`default_nettype none

// One line request of two endpoints on a 128 by 128 grid comes in on req and
// leaves as pixel pairs on pix, in Bresenham order, the last pair flagged by
// last_pair. After acceptance the setup states ST_SWAP and ST_ORDER pick the
// major axis and order the endpoints; then the walk unit takes two steps each
// cycle, so one pair leaves per cycle while pix is not stalled. From acceptance
// until the block can accept the next request, req_stall stays high.
module line_pixel_rasterizer
	import lpr_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         req_valid,
	output logic        req_stall,
	input  wire line_req_t req,
	output logic        pix_valid,
	input  wire         pix_stall,
	output pixel_pair_t pix
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWAP  = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;
	localparam logic [1:0] ST_RUN   = 2'd3;

	logic [1:0]  state_q;
	line_req_t   req_q;
	logic        steep_q;
	coord_t      pa_maj_q, pa_min_q, pb_maj_q, pb_min_q;
	line_par_t   par_q;
	walk_t       walk_q;
	cnt_t        rem_q;
	pixel_pair_t out_q;
	logic        out_valid_q;

	logic      accept, out_free, load, swap_ends, steep;
	coord_t    lo_maj, lo_min, hi_maj, hi_min, maj_span;
	coord_t    a_x, a_y, b_x, b_y;
	walk_t     nxt;
	logic      b_ok, last;

	function automatic coord_t span(input coord_t p, input coord_t q);
		return (p > q) ? p - q : q - p;
	endfunction

	lpr_step u_step (
		.cur (walk_q),
		.par (par_q),
		.a_x (a_x),
		.a_y (a_y),
		.b_x (b_x),
		.b_y (b_y),
		.nxt (nxt)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !pix_stall;
	assign load      = (state_q == ST_RUN) && out_free;
	assign b_ok      = rem_q > cnt_t'(1);
	assign last      = rem_q <= cnt_t'(2);
	assign pix_valid = out_valid_q;
	assign pix       = out_q;

	always_comb begin
		steep     = span(req_q.start_y, req_q.end_y) > span(req_q.start_x, req_q.end_x);
		swap_ends = pa_maj_q > pb_maj_q;
		lo_maj    = swap_ends ? pb_maj_q : pa_maj_q;
		lo_min    = swap_ends ? pb_min_q : pa_min_q;
		hi_maj    = swap_ends ? pa_maj_q : pb_maj_q;
		hi_min    = swap_ends ? pa_min_q : pb_min_q;
		maj_span  = hi_maj - lo_maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_SWAP;
				ST_SWAP:  state_q <= ST_ORDER;
				ST_ORDER: state_q <= ST_RUN;
				ST_RUN:   if (load && last) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ST_SWAP) begin
			steep_q  <= steep;
			pa_maj_q <= steep ? req_q.start_y : req_q.start_x;
			pa_min_q <= steep ? req_q.start_x : req_q.start_y;
			pb_maj_q <= steep ? req_q.end_y : req_q.end_x;
			pb_min_q <= steep ? req_q.end_x : req_q.end_y;
		end
		if (state_q == ST_ORDER) begin
			par_q.major_span <= maj_span;
			par_q.minor_span <= span(lo_min, hi_min);
			par_q.up         <= lo_min < hi_min;
			par_q.steep      <= steep_q;
			walk_q.major     <= lo_maj;
			walk_q.minor     <= lo_min;
			walk_q.err       <= to_err(maj_span >> 1);
			rem_q            <= {1'b0, maj_span} + cnt_t'(1);
		end
		if (load) begin
			walk_q              <= nxt;
			rem_q               <= rem_q - cnt_t'(2);
			out_q.pixel_a_x     <= a_x;
			out_q.pixel_a_y     <= a_y;
			out_q.pixel_b_x     <= b_ok ? b_x : coord_t'(0);
			out_q.pixel_b_y     <= b_ok ? b_y : coord_t'(0);
			out_q.pixel_b_valid <= b_ok;
			out_q.last_pair     <= last;
		end
	end

	a_run_err_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !walk_q.err[ERR_BITS-1])
		else $error("walk error term negative between steps");

	a_run_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rem_q != cnt_t'(0)))
		else $error("walk running with no pixels left");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last) |=> (state_q == ST_IDLE) && pix_valid && pix.last_pair)
		else $error("final pair did not end the line");

	a_pair_full: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix.last_pair) |-> pix.pixel_b_valid)
		else $error("non-final pair missing its second pixel");

endmodule

`default_nettype wire

FILE: sv/lpr_step.sv
// Walk unit: two Bresenham steps per cycle, giving one pixel pair.
// Depends on lpr_pkg.
`default_nettype none

module lpr_step
	import lpr_pkg::*;
(
	input  wire walk_t     cur,
	input  wire line_par_t par,
	output coord_t    a_x,
	output coord_t    a_y,
	output coord_t    b_x,
	output coord_t    b_y,
	output walk_t     nxt
);

	walk_t mid;

	function automatic walk_t advance(input walk_t w, input line_par_t p);
		err_t  e;
		walk_t r;
		e = w.err - to_err(p.minor_span);
		r.major = w.major + coord_t'(1);
		if (e < 0) begin
			r.minor = p.up ? w.minor + coord_t'(1) : w.minor - coord_t'(1);
			r.err   = e + to_err(p.major_span);
		end else begin
			r.minor = w.minor;
			r.err   = e;
		end
		return r;
	endfunction

	always_comb begin
		mid = advance(cur, par);
		nxt = advance(mid, par);
		a_x = par.steep ? cur.minor : cur.major;
		a_y = par.steep ? cur.major : cur.minor;
		b_x = par.steep ? mid.minor : mid.major;
		b_y = par.steep ? mid.major : mid.minor;
	end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench of line_pixel_rasterizer: directed and random line requests, each walked
// by a local Bresenham predictor and checked pair by pair, with idle and stall phases in the random runs.
// Depends on lpr_pkg and line_pixel_rasterizer.

module tb_top
	import lpr_pkg::*;
();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_LINES = 208;

	class pixel_scoreboard;
		pixel_pair_t pending_pairs[$];
		int lines_noted;
		int pairs_checked;
		int mismatches;

		function automatic int span(coord_t a, coord_t b);
			return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
		endfunction

		function void note_line(line_req_t r);
			coord_t ax, ay, bx, by, t, maj, mnr;
			int major_span, minor_span, err, count;
			bit steep, up;
			pixel_pair_t p;
			ax = r.start_x;
			ay = r.start_y;
			bx = r.end_x;
			by = r.end_y;
			steep = span(ay, by) > span(ax, bx);
			if (steep) begin
				t = ax; ax = ay; ay = t;
				t = bx; bx = by; by = t;
			end
			if (ax > bx) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			major_span = int'(bx) - int'(ax);
			minor_span = span(ay, by);
			err = major_span / 2;
			up = ay < by;
			maj = ax;
			mnr = ay;
			count = major_span + 1;
			p = '0;
			for (int k = 0; k < count; k++) begin
				if (k % 2 == 0) begin
					p = '0;
					p.pixel_a_x = steep ? mnr : maj;
					p.pixel_a_y = steep ? maj : mnr;
				end else begin
					p.pixel_b_x = steep ? mnr : maj;
					p.pixel_b_y = steep ? maj : mnr;
					p.pixel_b_valid = 1'b1;
				end
				if (k + 1 == count)
					p.last_pair = 1'b1;
				if (k % 2 == 1 || k + 1 == count)
					pending_pairs.push_back(p);
				err -= minor_span;
				if (err < 0) begin
					mnr = up ? mnr + 1'b1 : mnr - 1'b1;
					err += major_span;
				end
				maj = maj + 1'b1;
			end
			lines_noted++;
		endfunction

		function void compare_field(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$display("%0t mismatch in %s: expected %0d, actual %0d", $time, name, exp_v,
					act_v);
				mismatches++;
			end
		endfunction

		function void check_pair(pixel_pair_t got);
			pixel_pair_t exp_p;
			if (pending_pairs.size() == 0) begin
				$display("%0t unexpected pixel pair: expected none, actual %p", $time, got);
				mismatches++;
				return;
			end
			exp_p = pending_pairs.pop_front();
			compare_field("pixel_a_x", exp_p.pixel_a_x, got.pixel_a_x);
			compare_field("pixel_a_y", exp_p.pixel_a_y, got.pixel_a_y);
			compare_field("pixel_b_x", exp_p.pixel_b_x, got.pixel_b_x);
			compare_field("pixel_b_y", exp_p.pixel_b_y, got.pixel_b_y);
			compare_field("pixel_b_valid", exp_p.pixel_b_valid, got.pixel_b_valid);
			compare_field("last_pair", exp_p.last_pair, got.last_pair);
			pairs_checked++;
		endfunction

		function int pending();
			return pending_pairs.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	line_req_t   req;
	logic        pix_valid;
	logic        pix_stall;
	pixel_pair_t pix;

	pixel_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_on;
	int cycles;

	line_pixel_rasterizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		pix_stall = 1'b0;
		hold_on = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycles = 0;
		sb = new();
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pairs still expected", cycles,
				sb.pending());
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			sb.check_pair(pix);
	end

	always @(negedge clk) begin
		pix_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
	end

	function automatic coord_t near(coord_t base);
		int v;
		v = int'(base) + $urandom_range(0, 14) - 7;
		if (v < 0)
			v = 0;
		if (v > 127)
			v = 127;
		return coord_t'(v);
	endfunction

	function automatic line_req_t random_line();
		line_req_t r;
		int pick;
		pick = $urandom_range(0, 9);
		r.start_x = coord_t'($urandom);
		r.start_y = coord_t'($urandom);
		r.end_x = coord_t'($urandom);
		r.end_y = coord_t'($urandom);
		if (pick >= 6 && pick <= 8) begin
			r.end_x = near(r.start_x);
			r.end_y = near(r.start_y);
		end else if (pick == 9) begin
			case ($urandom_range(0, 2))
				0: r.end_x = r.start_x;
				1: r.end_y = r.start_y;
				default: begin
					r.end_x = r.start_x;
					r.end_y = r.start_y;
				end
			endcase
		end
		return r;
	endfunction

	task automatic send_line(line_req_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req = r;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_line(r);
	endtask

	task automatic send_random(int n);
		repeat (n)
			send_line(random_line());
	endtask

	task automatic send_directed();
		line_req_t lines[$];
		lines = '{
			'{7'd0, 7'd0, 7'd0, 7'd0},
			'{7'd127, 7'd127, 7'd127, 7'd127},
			'{7'd0, 7'd0, 7'd127, 7'd0},
			'{7'd127, 7'd0, 7'd0, 7'd0},
			'{7'd0, 7'd0, 7'd0, 7'd127},
			'{7'd0, 7'd127, 7'd0, 7'd0},
			'{7'd0, 7'd0, 7'd127, 7'd127},
			'{7'd127, 7'd0, 7'd0, 7'd127},
			'{7'd0, 7'd0, 7'd127, 7'd1},
			'{7'd3, 7'd5, 7'd10, 7'd8},
			'{7'd3, 7'd5, 7'd9, 7'd8},
			'{7'd5, 7'd3, 7'd8, 7'd10},
			'{7'd8, 7'd10, 7'd5, 7'd3},
			'{7'd10, 7'd2, 7'd3, 7'd6},
			'{7'd2, 7'd10, 7'd6, 7'd3},
			'{7'd85, 7'd42, 7'd42, 7'd85},
			'{7'd42, 7'd85, 7'd85, 7'd42},
			'{7'd0, 7'd1, 7'd1, 7'd0},
			'{7'd64, 7'd63, 7'd63, 7'd64},
			'{7'd1, 7'd0, 7'd0, 7'd0},
			'{7'd127, 7'd126, 7'd0, 7'd0}
		};
		foreach (lines[i])
			send_line(lines[i]);
	endtask

	initial begin
		#1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_directed();

		fork
			send_random(RANDOM_LINES / 4);
			begin
				repeat (200) @(posedge clk);
				hold_on = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on = 1'b0;
			end
		join

		send_idle_pct = 59;
		recv_stall_pct = 0;
		send_random(RANDOM_LINES / 4);

		send_idle_pct = 0;
		recv_stall_pct = 59;
		send_random(RANDOM_LINES / 4);

		send_idle_pct = 18;
		recv_stall_pct = 18;
		send_random(RANDOM_LINES / 4);

		@(negedge clk);
		req_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d line requests walked, %0d pixel pairs checked in %0d cycles,",
			sb.lines_noted, sb.pairs_checked, cycles);
		$display("across free-running, sender-idle, receiver-stall and mixed phases");
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
